@@ rtl/lrc_pkg.sv @@
// lrc_pkg: widths, operation codes and shared types of the LRU result cache.
// No dependencies; every other file takes its names by scope from here.
`default_nettype none

package lrc_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int KEY_W   = 64;
    localparam int EST_W   = 32;
    localparam int ST_W    = 2;
    localparam int OP_W    = 2;

    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [EST_W-1:0] time_est;
        logic [EST_W-1:0] io_est;
        logic [KEY_W-1:0] key;
    } t_entry;

    typedef struct packed {
        logic             hit;
        logic [ST_W-1:0]  status;
        logic [EST_W-1:0] time_est;
        logic [EST_W-1:0] io_est;
    } t_result;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic scan_issue;
        logic idx_inc;
        logic rscan_step;
        logic update;
        logic load_out;
    } t_ctl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic            count_zero;
        logic            full;
        logic            scan_last;
        logic            idx_last;
        logic            out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

@@ rtl/lrc_if.sv @@
// lrc_req_if / lrc_rsp_if: valid-ready channels carrying cache requests and results.
// Depends on lrc_pkg for field widths.
`default_nettype none

interface lrc_req_if;
    logic                     valid;
    logic                     ready;
    logic [lrc_pkg::OP_W-1:0]  operation;
    logic [lrc_pkg::KEY_W-1:0] key;
    logic [lrc_pkg::ST_W-1:0]  status_in;
    logic [lrc_pkg::EST_W-1:0] time_estimate_in;
    logic [lrc_pkg::EST_W-1:0] io_estimate_in;

    modport source (output valid, operation, key, status_in, time_estimate_in,
                    io_estimate_in, input ready);
    modport sink   (input valid, operation, key, status_in, time_estimate_in,
                    io_estimate_in, output ready);
endinterface

interface lrc_rsp_if;
    logic                     valid;
    logic                     ready;
    logic                     hit;
    logic [lrc_pkg::ST_W-1:0]  status_out;
    logic [lrc_pkg::EST_W-1:0] time_estimate_out;
    logic [lrc_pkg::EST_W-1:0] io_estimate_out;

    modport source (output valid, hit, status_out, time_estimate_out, io_estimate_out,
                    input ready);
    modport sink   (input valid, hit, status_out, time_estimate_out, io_estimate_out,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/lrc_datapath.sv @@
// lrc_datapath: entry memory, recency ranks, entry count, scan compare and output register.
// Depends on lrc_pkg; driven by lrc_ctrl through t_ctl_cmd.
`default_nettype none

module lrc_datapath (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire lrc_pkg::t_ctl_cmd         i_cmd,
    output lrc_pkg::t_dp_stat              o_stat,
    input  wire logic [lrc_pkg::OP_W-1:0]  i_operation,
    input  wire logic [lrc_pkg::KEY_W-1:0] i_key,
    input  wire logic [lrc_pkg::ST_W-1:0]  i_status_in,
    input  wire logic [lrc_pkg::EST_W-1:0] i_time_estimate_in,
    input  wire logic [lrc_pkg::EST_W-1:0] i_io_estimate_in,
    input  wire logic                      i_out_ready,
    output logic                           o_out_valid,
    output lrc_pkg::t_result               o_result
);

    // latched request
    logic [lrc_pkg::OP_W-1:0]  r_op;
    lrc_pkg::t_entry           r_req;

    logic [lrc_pkg::CNT_W-1:0] r_count;
    logic [lrc_pkg::IDX_W-1:0] r_rank [lrc_pkg::ENTRIES];
    lrc_pkg::t_entry           r_mem  [lrc_pkg::ENTRIES];
    lrc_pkg::t_entry           r_rd;

    logic [lrc_pkg::IDX_W-1:0] r_idx;
    logic                      r_cmp_vld;
    logic [lrc_pkg::IDX_W-1:0] r_cmp_idx;

    logic                      r_found;
    logic [lrc_pkg::IDX_W-1:0] r_best;
    logic [lrc_pkg::IDX_W-1:0] r_best_rank;
    lrc_pkg::t_entry           r_best_data;

    lrc_pkg::t_result          r_res;
    lrc_pkg::t_result          r_out;
    logic                      r_out_valid;

    logic                      is_lookup;
    logic                      is_insert;
    logic                      full;
    logic                      cmp_better;
    logic                      promote_en;
    logic                      res_hit;
    logic [lrc_pkg::IDX_W-1:0] upd_slot;
    logic [lrc_pkg::CNT_W-1:0] upd_limit;

    assign is_lookup = (r_op == lrc_pkg::OP_LOOKUP);
    assign is_insert = (r_op == lrc_pkg::OP_INSERT);
    assign full      = (r_count == lrc_pkg::CNT_W'(lrc_pkg::ENTRIES));

    assign cmp_better = r_cmp_vld && (r_rd.key == r_req.key)
                        && (!r_found || (r_rank[r_cmp_idx] < r_best_rank));

    // slot to make most recent and the rank bound below which others age
    assign upd_slot  = (is_lookup || full) ? r_best : r_count[lrc_pkg::IDX_W-1:0];
    assign upd_limit = is_lookup ? lrc_pkg::CNT_W'(r_best_rank)
                     : (full ? lrc_pkg::CNT_W'(lrc_pkg::ENTRIES - 1) : r_count);
    assign promote_en = i_cmd.update && ((is_lookup && r_found) || is_insert);
    assign res_hit    = is_lookup && r_found;

    always_comb begin
        o_stat.count_zero = (r_count == '0);
        o_stat.full       = full;
        o_stat.scan_last  = (lrc_pkg::CNT_W'(r_idx) == (r_count - lrc_pkg::CNT_W'(1)));
        o_stat.idx_last   = (r_idx == lrc_pkg::IDX_W'(lrc_pkg::ENTRIES - 1));
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op            <= i_operation;
            r_req.key       <= i_key;
            r_req.status    <= i_status_in;
            r_req.time_est  <= i_time_estimate_in;
            r_req.io_est    <= i_io_estimate_in;
        end
        r_cmp_idx <= r_idx;
        if (cmp_better) begin
            r_best      <= r_cmp_idx;
            r_best_rank <= r_rank[r_cmp_idx];
            r_best_data <= r_rd;
        end
        if (i_cmd.rscan_step && (r_rank[r_idx] == lrc_pkg::IDX_W'(lrc_pkg::ENTRIES - 1))) begin
            r_best <= r_idx;
        end
        if (i_cmd.update) begin
            r_res.hit      <= res_hit;
            r_res.status   <= res_hit ? r_best_data.status   : '0;
            r_res.time_est <= res_hit ? r_best_data.time_est : '0;
            r_res.io_est   <= res_hit ? r_best_data.io_est   : '0;
        end
        if (i_cmd.load_out) begin
            r_out <= r_res;
        end
    end

    // entry store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.update && is_insert) begin
            r_mem[upd_slot] <= r_req;
        end
        r_rd <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < lrc_pkg::ENTRIES; i++) begin
            if (promote_en) begin
                if (lrc_pkg::IDX_W'(i) == upd_slot) begin
                    r_rank[i] <= '0;
                end else if ((lrc_pkg::CNT_W'(i) < r_count)
                             && (lrc_pkg::CNT_W'(r_rank[i]) < upd_limit)) begin
                    r_rank[i] <= r_rank[i] + lrc_pkg::IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_cmp_vld   <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan_issue;
            if (i_cmd.accept) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + lrc_pkg::IDX_W'(1);
            end
            if (i_cmd.accept) begin
                r_found <= 1'b0;
            end else if (cmp_better) begin
                r_found <= 1'b1;
            end
            if (i_cmd.update && is_insert && !full) begin
                r_count <= r_count + lrc_pkg::CNT_W'(1);
            end else if (i_cmd.update && (r_op == lrc_pkg::OP_CLEAR)) begin
                r_count <= '0;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= lrc_pkg::CNT_W'(lrc_pkg::ENTRIES))
        else $error("entry count above capacity");

    a_insert_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && is_insert && !full) |=> (r_count == $past(r_count) + lrc_pkg::CNT_W'(1)))
        else $error("insert into non-full cache did not grow the count");

    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && (r_op == lrc_pkg::OP_CLEAR)) |=> (r_count == '0))
        else $error("clear left entries behind");

endmodule

`default_nettype wire

@@ rtl/lrc_ctrl.sv @@
// lrc_ctrl: sequencer for lookup scan, LRU victim search, update and result hand-off.
// Depends on lrc_pkg; commands lrc_datapath through t_ctl_cmd.
`default_nettype none

module lrc_ctrl (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    input  wire logic [lrc_pkg::OP_W-1:0] i_in_op,
    output logic                          o_in_ready,
    input  wire lrc_pkg::t_dp_stat        i_stat,
    output lrc_pkg::t_ctl_cmd             o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_DRAIN  = 6'b000100,
        S_RSCAN  = 6'b001000,
        S_UPDATE = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                // hold off transfers while in reset
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.accept = 1'b1;
                    case (i_in_op)
                        lrc_pkg::OP_LOOKUP: n_state = i_stat.count_zero ? S_UPDATE : S_SCAN;
                        lrc_pkg::OP_INSERT: n_state = i_stat.full ? S_RSCAN : S_UPDATE;
                        default:            n_state = S_UPDATE;
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.scan_issue = 1'b1;
                o_cmd.idx_inc    = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // last compare lands this cycle
                n_state = S_UPDATE;
            end
            S_RSCAN: begin
                o_cmd.rscan_step = 1'b1;
                o_cmd.idx_inc    = 1'b1;
                if (i_stat.idx_last) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state register not one-hot");

    a_no_empty_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.scan_issue |-> !i_stat.count_zero)
        else $error("scan issued on an empty cache");

    a_out_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_stat.out_free)
        else $error("result loaded over an untaken result");

endmodule

`default_nettype wire

@@ rtl/lru_result_cache.sv @@
// lru_result_cache: top level of the fully associative LRU result cache.
// Depends on lrc_pkg, lrc_if, lrc_ctrl and lrc_datapath.
//
//   channel  dir  modport  payload
//   i_req    in   sink     operation, key, status_in, time_estimate_in, io_estimate_in
//   o_rsp    out  source   hit, status_out, time_estimate_out, io_estimate_out
//
// One item at a time. A lookup walks the valid entries one per cycle through the
// entry memory read port, or skips the walk on an empty cache. An insert into a
// full cache walks all rank registers; other inserts, clears and unused codes go
// straight to update. Reset is synchronous and empties the cache; no clearing pass.
// The result waits in an output register; a stalled o_rsp holds only the next result.
`default_nettype none

module lru_result_cache (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    lrc_req_if.sink   i_req,
    lrc_rsp_if.source o_rsp
);

    lrc_pkg::t_ctl_cmd cmd;
    lrc_pkg::t_dp_stat stat;
    lrc_pkg::t_result  result;

    lrc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_in_op    (i_req.operation),
        .o_in_ready (i_req.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    lrc_datapath u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_operation        (i_req.operation),
        .i_key              (i_req.key),
        .i_status_in        (i_req.status_in),
        .i_time_estimate_in (i_req.time_estimate_in),
        .i_io_estimate_in   (i_req.io_estimate_in),
        .i_out_ready        (o_rsp.ready),
        .o_out_valid        (o_rsp.valid),
        .o_result           (result)
    );

    assign o_rsp.hit               = result.hit;
    assign o_rsp.status_out        = result.status;
    assign o_rsp.time_estimate_out = result.time_est;
    assign o_rsp.io_estimate_out   = result.io_est;

endmodule

`default_nettype wire
